// ===== src/id3_pkg.sv =====
// shared types, codes and helpers for the id3v2 frame parser
`timescale 1ns / 1ps

package id3_pkg;

	// parser phase codes
	localparam logic [3:0] PH_HDR       = 4'd0;
	localparam logic [3:0] PH_FHDR      = 4'd1;
	localparam logic [3:0] PH_TEXT      = 4'd2;
	localparam logic [3:0] PH_APIC_ENC  = 4'd3;
	localparam logic [3:0] PH_APIC_MIME = 4'd4;
	localparam logic [3:0] PH_APIC_TYPE = 4'd5;
	localparam logic [3:0] PH_APIC_DESC = 4'd6;
	localparam logic [3:0] PH_APIC_IMG  = 4'd7;
	localparam logic [3:0] PH_SKIP      = 4'd8;
	localparam logic [3:0] PH_ENDPEND   = 4'd9;
	localparam logic [3:0] PH_IDLE      = 4'd10;

	// field kinds
	localparam logic [2:0] KIND_TITLE   = 3'd0;
	localparam logic [2:0] KIND_ARTIST  = 3'd1;
	localparam logic [2:0] KIND_ALBUM   = 3'd2;
	localparam logic [2:0] KIND_YEAR    = 3'd3;
	localparam logic [2:0] KIND_COMMENT = 3'd4;
	localparam logic [2:0] KIND_GENRE   = 3'd5;
	localparam logic [2:0] KIND_IMAGE   = 3'd6;
	localparam logic [2:0] KIND_STATUS  = 3'd7;

	// status codes
	localparam logic [1:0] ST_DATA    = 2'd0;
	localparam logic [1:0] ST_NO_ID3  = 2'd1;
	localparam logic [1:0] ST_TAG_END = 2'd2;
	localparam logic [1:0] ST_BAD_SZ  = 2'd3;

	// frame ids and tag mark
	localparam logic [31:0] ID_TIT2  = 32'h5449_5432;
	localparam logic [31:0] ID_TPE1  = 32'h5450_4531;
	localparam logic [31:0] ID_TALB  = 32'h5441_4C42;
	localparam logic [31:0] ID_TYER  = 32'h5459_4552;
	localparam logic [31:0] ID_COMM  = 32'h434F_4D4D;
	localparam logic [31:0] ID_TCON  = 32'h5443_4F4E;
	localparam logic [31:0] ID_APIC  = 32'h4150_4943;
	localparam logic [23:0] MARK_ID3 = 24'h49_4433;

	// header bounds: last byte index of a header and frame header length
	localparam logic [30:0] HDR_LAST    = 31'd9;
	localparam logic [31:0] FHDR_LEN    = 32'd10;

	// one input byte with its restart flag
	typedef struct packed {
		logic       start_of_file;
		logic [7:0] data_byte;
	} item_t;

	// one result
	typedef struct packed {
		logic [1:0] status;
		logic       last_of_field;
		logic [7:0] out_byte;
		logic [2:0] field_kind;
	} result_t;

	// text frame kind; valid flag in the top bit
	typedef struct packed {
		logic       is_text;
		logic [2:0] kind;
	} text_kind_t;

	function automatic text_kind_t text_kind(input logic [31:0] id);
		text_kind_t tk;
		tk.is_text = 1'b1;
		case (id)
			ID_TIT2: tk.kind = KIND_TITLE;
			ID_TPE1: tk.kind = KIND_ARTIST;
			ID_TALB: tk.kind = KIND_ALBUM;
			ID_TYER: tk.kind = KIND_YEAR;
			ID_COMM: tk.kind = KIND_COMMENT;
			ID_TCON: tk.kind = KIND_GENRE;
			default: begin
				tk.is_text = 1'b0;
				tk.kind    = KIND_TITLE;
			end
		endcase
		return tk;
	endfunction

endpackage

// ===== src/id3v2_frame_parser_top.sv =====
// top level of the id3v2 tag frame parser
`timescale 1ns / 1ps
//
// channel   direction  tdata            tuser                          tlast
// s_axis    in         data_byte [7:0]  start_of_file [0]              -
// m_axis    out        out_byte [7:0]   field_kind [2:0], status [4:3] last_of_field
//
// one byte per cycle sustained while m_axis does not stall; a byte passes the input
// register, which feeds the combinational parse step that loads the result register;
// many bytes give no result transaction. reset puts the parser in the tag header
// phase; a byte with start_of_file set restarts it. a stall on m_axis holds the
// result and the input register, and s_axis keeps taking bytes as long as the input
// register can move on.

module id3v2_frame_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,  // [0] start_of_file
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
	output logic [4:0]  m_axis_tuser,  // [2:0] field_kind, [4:3] status
	output logic        m_axis_tlast   // last_of_field
);

	id3_pkg::item_t   in_item;
	id3_pkg::item_t   item;
	logic             item_valid;
	logic             take;
	id3_pkg::result_t res;

	assign in_item.data_byte     = s_axis_tdata;
	assign in_item.start_of_file = s_axis_tuser[0];

	// input register
	id3_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item       (item),
		.take       (take)
	);

	// parse step and result register
	id3_parse_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.take       (take),
		.res_valid  (m_axis_tvalid),
		.res        (res),
		.res_ready  (m_axis_tready)
	);

	// result transaction fields
	assign m_axis_tdata = res.out_byte;
	assign m_axis_tuser = {res.status, res.field_kind};
	assign m_axis_tlast = res.last_of_field;

endmodule

// ===== src/id3_in_stage.sv =====
// input register stage that holds one accepted byte until the parser takes it
`timescale 1ns / 1ps

module id3_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  id3_pkg::item_t      in_item,
	output logic                item_valid,
	output id3_pkg::item_t      item,
	input  logic                take
);

	logic           valid_s1;
	id3_pkg::item_t item_s1;

	// room when empty or when the held byte leaves this cycle
	assign in_ready   = !valid_s1 || take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== src/id3_parse_core.sv =====
// parser state, per-byte next-state logic and the result register
`timescale 1ns / 1ps

module id3_parse_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  id3_pkg::item_t      item,
	output logic                take,
	output logic                res_valid,
	output id3_pkg::result_t    res,
	input  logic                res_ready
);

	logic [3:0]  phase_q;
	logic [30:0] cnt_q;
	logic [31:0] tag_size_q;
	logic [31:0] consumed_q;
	logic [31:0] frame_id_q;
	logic [31:0] frame_size_q;
	logic        text_done_q;

	logic [3:0]  ph;
	logic [30:0] cnt;
	logic [31:0] tag;
	logic [31:0] cons;
	logic [31:0] fid;
	logic [31:0] fsz;
	logic        td;

	logic [3:0]  n_ph;
	logic [30:0] n_cnt;
	logic [31:0] n_tag;
	logic [31:0] n_cons;
	logic [31:0] n_fid;
	logic [31:0] n_fsz;
	logic        n_td;

	logic                 hit;
	id3_pkg::result_t     hit_res;
	id3_pkg::text_kind_t  tk;
	logic                 fin;
	logic [7:0]           b;

	logic             res_valid_q;
	id3_pkg::result_t res_q;

	// a byte is processed when the result register is free or its result leaves this cycle
	assign take      = item_valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign b         = item.data_byte;

	// state as seen by this byte, after a possible restart
	always_comb begin
		if (item.start_of_file) begin
			ph   = id3_pkg::PH_HDR;
			cnt  = '0;
			tag  = '0;
			cons = '0;
			fid  = '0;
			fsz  = '0;
			td   = 1'b0;
		end else begin
			ph   = phase_q;
			cnt  = cnt_q;
			tag  = tag_size_q;
			cons = consumed_q;
			fid  = frame_id_q;
			fsz  = frame_size_q;
			td   = text_done_q;
		end
	end

	assign tk  = id3_pkg::text_kind(fid);
	assign fin = (({1'b0, cnt} + 32'd1) == fsz);

	// per-byte parse step
	always_comb begin
		n_ph    = ph;
		n_cnt   = cnt;
		n_tag   = tag;
		n_cons  = cons;
		n_fid   = fid;
		n_fsz   = fsz;
		n_td    = td;
		hit     = 1'b0;
		hit_res = '0;
		case (ph)
			id3_pkg::PH_HDR: begin
				if (cnt < 31'd3) begin
					n_fid = {fid[23:0], b};
				end
				if (cnt >= 31'd6) begin
					n_tag = {tag[24:0], 7'd0} | {24'd0, b};
				end
				if (cnt < id3_pkg::HDR_LAST) begin
					n_cnt = cnt + 31'd1;
				end else begin
					n_cnt = '0;
					n_ph  = id3_pkg::PH_IDLE;
					if (n_fid[23:0] != id3_pkg::MARK_ID3) begin
						hit                = 1'b1;
						hit_res.field_kind = id3_pkg::KIND_STATUS;
						hit_res.status     = id3_pkg::ST_NO_ID3;
					end else if (n_tag == 32'd0) begin
						hit                = 1'b1;
						hit_res.field_kind = id3_pkg::KIND_STATUS;
						hit_res.status     = id3_pkg::ST_TAG_END;
					end else begin
						n_cons = '0;
						n_ph   = id3_pkg::PH_FHDR;
					end
				end
			end
			id3_pkg::PH_FHDR: begin
				if (cnt < 31'd4) begin
					n_fid = {fid[23:0], b};
				end else if (cnt < 31'd8) begin
					n_fsz = {fsz[23:0], b};
				end
				if (cnt < id3_pkg::HDR_LAST) begin
					n_cnt = cnt + 31'd1;
				end else begin
					n_cnt = '0;
					if (fsz == 32'd0 || fsz[31]) begin
						n_ph               = id3_pkg::PH_IDLE;
						hit                = 1'b1;
						hit_res.field_kind = id3_pkg::KIND_STATUS;
						hit_res.status     = id3_pkg::ST_BAD_SZ;
					end else begin
						n_cons = cons + id3_pkg::FHDR_LEN + fsz;
						n_td   = 1'b0;
						if (tk.is_text) begin
							n_ph = id3_pkg::PH_TEXT;
						end else if (fid == id3_pkg::ID_APIC) begin
							n_ph = id3_pkg::PH_APIC_ENC;
						end else begin
							n_ph = id3_pkg::PH_SKIP;
						end
					end
				end
			end
			id3_pkg::PH_TEXT, id3_pkg::PH_APIC_ENC, id3_pkg::PH_APIC_MIME,
			id3_pkg::PH_APIC_TYPE, id3_pkg::PH_APIC_DESC, id3_pkg::PH_APIC_IMG,
			id3_pkg::PH_SKIP: begin
				// body byte handling per sub-phase
				case (ph)
					id3_pkg::PH_TEXT: begin
						if (cnt == 31'd0) begin
							if (fin) begin
								hit                   = 1'b1;
								hit_res.field_kind    = tk.kind;
								hit_res.last_of_field = 1'b1;
								n_td                  = 1'b1;
							end
						end else if (!td) begin
							hit                = 1'b1;
							hit_res.field_kind = tk.kind;
							if (b == 8'd0) begin
								hit_res.last_of_field = 1'b1;
								n_td                  = 1'b1;
							end else begin
								hit_res.out_byte      = b;
								hit_res.last_of_field = fin;
							end
						end
					end
					id3_pkg::PH_APIC_ENC: n_ph = id3_pkg::PH_APIC_MIME;
					id3_pkg::PH_APIC_MIME: begin
						if (b == 8'd0) begin
							n_ph = id3_pkg::PH_APIC_TYPE;
						end
					end
					id3_pkg::PH_APIC_TYPE: n_ph = id3_pkg::PH_APIC_DESC;
					id3_pkg::PH_APIC_DESC: begin
						if (b == 8'd0) begin
							n_ph = id3_pkg::PH_APIC_IMG;
						end
					end
					id3_pkg::PH_APIC_IMG: begin
						hit                   = 1'b1;
						hit_res.field_kind    = id3_pkg::KIND_IMAGE;
						hit_res.out_byte      = b;
						hit_res.last_of_field = fin;
					end
					default: begin
					end
				endcase
				// frame end and tag end check
				n_cnt = cnt + 31'd1;
				if (fin) begin
					n_cnt = '0;
					if (cons >= tag) begin
						if (!hit) begin
							hit                = 1'b1;
							hit_res.field_kind = id3_pkg::KIND_STATUS;
							hit_res.status     = id3_pkg::ST_TAG_END;
							n_ph               = id3_pkg::PH_IDLE;
						end else begin
							n_ph = id3_pkg::PH_ENDPEND;
						end
					end else begin
						n_ph = id3_pkg::PH_FHDR;
					end
				end
			end
			id3_pkg::PH_ENDPEND: begin
				n_ph               = id3_pkg::PH_IDLE;
				hit                = 1'b1;
				hit_res.field_kind = id3_pkg::KIND_STATUS;
				hit_res.status     = id3_pkg::ST_TAG_END;
			end
			default: begin
				n_ph = id3_pkg::PH_IDLE;
			end
		endcase
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= id3_pkg::PH_HDR;
			cnt_q        <= '0;
			tag_size_q   <= '0;
			consumed_q   <= '0;
			frame_id_q   <= '0;
			frame_size_q <= '0;
			text_done_q  <= 1'b0;
		end else if (take) begin
			phase_q      <= n_ph;
			cnt_q        <= n_cnt;
			tag_size_q   <= n_tag;
			consumed_q   <= n_cons;
			frame_id_q   <= n_fid;
			frame_size_q <= n_fsz;
			text_done_q  <= n_td;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= hit;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take && hit) begin
			res_q <= hit_res;
		end
	end

endmodule

// ===== verif/id3_field_check.sv =====
// checker that predicts and compares the field transactions of the id3v2 parser
`timescale 1ns / 1ps

module id3_field_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0] s_axis_tuser,  // [0] start_of_file
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,  // [7:0] out_byte
	input  logic [4:0] m_axis_tuser,  // [2:0] field_kind, [4:3] status
	input  logic       m_axis_tlast,  // last_of_field
	output int         fail_count,
	output int         outstanding
);

	// marks an id that is not a text frame
	localparam logic [3:0] NO_TEXT = 4'd8;

	// parser state as the predictor tracks it
	logic [3:0]  ph;
	logic [31:0] pos;
	logic [31:0] tag_len;
	logic [31:0] used_len;
	logic [31:0] cur_id;
	logic [31:0] cur_size;
	logic        text_ended;

	id3_pkg::result_t expected_fields[$];
	id3_pkg::result_t want;
	int               mismatches;

	// text frame id to field kind, NO_TEXT for anything else
	function automatic logic [3:0] text_field(input logic [31:0] id);
		case (id)
			id3_pkg::ID_TIT2: return {1'b0, id3_pkg::KIND_TITLE};
			id3_pkg::ID_TPE1: return {1'b0, id3_pkg::KIND_ARTIST};
			id3_pkg::ID_TALB: return {1'b0, id3_pkg::KIND_ALBUM};
			id3_pkg::ID_TYER: return {1'b0, id3_pkg::KIND_YEAR};
			id3_pkg::ID_COMM: return {1'b0, id3_pkg::KIND_COMMENT};
			id3_pkg::ID_TCON: return {1'b0, id3_pkg::KIND_GENRE};
			default: return NO_TEXT;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic emit(input logic [2:0] kind, input logic [7:0] b, input logic last,
			input logic [1:0] st);
		id3_pkg::result_t r;
		r.field_kind    = kind;
		r.out_byte      = b;
		r.last_of_field = last;
		r.status        = st;
		expected_fields.push_back(r);
	endtask

	task automatic restart_parser();
		ph         = id3_pkg::PH_HDR;
		pos        = 32'd0;
		tag_len    = 32'd0;
		used_len   = 32'd0;
		cur_id     = 32'd0;
		cur_size   = 32'd0;
		text_ended = 1'b0;
	endtask

	// advance the parser by one file byte and queue any field it gives
	task automatic parse_file_byte(input logic [7:0] b, input logic sof);
		logic       fin;
		logic [3:0] tk;
		logic       made;
		if (sof)
			restart_parser();
		fin  = (pos + 32'd1 == cur_size);
		tk   = text_field(cur_id);
		made = 1'b0;
		case (ph)
			id3_pkg::PH_HDR: begin
				if (pos < 32'd3)
					cur_id = {cur_id[23:0], b};
				// tag size keeps all eight bits of each byte
				if (pos >= 32'd6)
					tag_len = {tag_len[24:0], 7'd0} | {24'd0, b};
				if (pos < 32'd9) begin
					pos = pos + 32'd1;
				end else begin
					pos = 32'd0;
					ph  = id3_pkg::PH_IDLE;
					if (cur_id[23:0] != id3_pkg::MARK_ID3) begin
						emit(id3_pkg::KIND_STATUS, 8'd0, 1'b0, id3_pkg::ST_NO_ID3);
					end else if (tag_len == 32'd0) begin
						emit(id3_pkg::KIND_STATUS, 8'd0, 1'b0, id3_pkg::ST_TAG_END);
					end else begin
						used_len = 32'd0;
						ph       = id3_pkg::PH_FHDR;
					end
				end
			end
			id3_pkg::PH_FHDR: begin
				if (pos < 32'd4)
					cur_id = {cur_id[23:0], b};
				else if (pos < 32'd8)
					cur_size = {cur_size[23:0], b};
				if (pos < 32'd9) begin
					pos = pos + 32'd1;
				end else begin
					pos = 32'd0;
					if (cur_size == 32'd0 || cur_size[31]) begin
						ph = id3_pkg::PH_IDLE;
						emit(id3_pkg::KIND_STATUS, 8'd0, 1'b0, id3_pkg::ST_BAD_SZ);
					end else begin
						used_len   = used_len + id3_pkg::FHDR_LEN + cur_size;
						text_ended = 1'b0;
						if (text_field(cur_id) != NO_TEXT)
							ph = id3_pkg::PH_TEXT;
						else if (cur_id == id3_pkg::ID_APIC)
							ph = id3_pkg::PH_APIC_ENC;
						else
							ph = id3_pkg::PH_SKIP;
					end
				end
			end
			id3_pkg::PH_TEXT, id3_pkg::PH_APIC_ENC, id3_pkg::PH_APIC_MIME,
			id3_pkg::PH_APIC_TYPE, id3_pkg::PH_APIC_DESC, id3_pkg::PH_APIC_IMG,
			id3_pkg::PH_SKIP: begin
				case (ph)
					id3_pkg::PH_TEXT: begin
						// encoding byte gives only the end marker of a one-byte frame
						if (pos == 32'd0) begin
							if (fin) begin
								emit(tk[2:0], 8'd0, 1'b1, id3_pkg::ST_DATA);
								made       = 1'b1;
								text_ended = 1'b1;
							end
						end else if (!text_ended) begin
							if (b == 8'd0) begin
								emit(tk[2:0], 8'd0, 1'b1, id3_pkg::ST_DATA);
								text_ended = 1'b1;
							end else begin
								emit(tk[2:0], b, fin, id3_pkg::ST_DATA);
							end
							made = 1'b1;
						end
					end
					id3_pkg::PH_APIC_ENC:  ph = id3_pkg::PH_APIC_MIME;
					id3_pkg::PH_APIC_MIME: if (b == 8'd0) ph = id3_pkg::PH_APIC_TYPE;
					id3_pkg::PH_APIC_TYPE: ph = id3_pkg::PH_APIC_DESC;
					id3_pkg::PH_APIC_DESC: if (b == 8'd0) ph = id3_pkg::PH_APIC_IMG;
					id3_pkg::PH_APIC_IMG: begin
						emit(id3_pkg::KIND_IMAGE, b, fin, id3_pkg::ST_DATA);
						made = 1'b1;
					end
					default: ;
				endcase
				pos = pos + 32'd1;
				// frame end: next header, or tag end now or on the next byte
				if (fin) begin
					pos = 32'd0;
					if (used_len >= tag_len) begin
						if (!made) begin
							emit(id3_pkg::KIND_STATUS, 8'd0, 1'b0, id3_pkg::ST_TAG_END);
							ph = id3_pkg::PH_IDLE;
						end else begin
							ph = id3_pkg::PH_ENDPEND;
						end
					end else begin
						ph = id3_pkg::PH_FHDR;
					end
				end
			end
			id3_pkg::PH_ENDPEND: begin
				ph = id3_pkg::PH_IDLE;
				emit(id3_pkg::KIND_STATUS, 8'd0, 1'b0, id3_pkg::ST_TAG_END);
			end
			default: ph = id3_pkg::PH_IDLE;
		endcase
	endtask

	// predict on each input transaction, compare each output transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_parser();
			expected_fields.delete();
			mismatches  = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				parse_file_byte(s_axis_tdata, s_axis_tuser[0]);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_fields.size() == 0) begin
					report_mismatch($sformatf(
						"unexpected result kind %0d byte %02h last %0b status %0d",
						m_axis_tuser[2:0], m_axis_tdata, m_axis_tlast, m_axis_tuser[4:3]));
				end else begin
					want = expected_fields.pop_front();
					if (m_axis_tuser[2:0] !== want.field_kind)
						report_mismatch($sformatf("field_kind %0d, expected %0d",
							m_axis_tuser[2:0], want.field_kind));
					if (m_axis_tdata !== want.out_byte)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							m_axis_tdata, want.out_byte));
					if (m_axis_tlast !== want.last_of_field)
						report_mismatch($sformatf("last_of_field %0b, expected %0b",
							m_axis_tlast, want.last_of_field));
					if (m_axis_tuser[4:3] !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							m_axis_tuser[4:3], want.status));
				end
			end
			fail_count  <= mismatches;
			outstanding <= expected_fields.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
// stimulus and verdict for the id3v2 frame parser, checked by id3_field_check
`timescale 1ns / 1ps

module testbench;

	localparam int ITEM_TARGET    = 2000;
	localparam int GAP_PCT        = 9;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 16;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic [7:0] s_axis_tdata  = 8'd0;
	logic [0:0] s_axis_tuser  = 1'b0;
	logic       m_axis_tready = 1'b0;
	logic       s_axis_tready;
	logic       m_axis_tvalid;
	logic [7:0] m_axis_tdata;
	logic [4:0] m_axis_tuser;
	logic       m_axis_tlast;
	int         fail_count;
	int         outstanding;

	// no idling on either side while set
	logic           steady = 1'b0;
	int             quiet  = 0;
	int             sent   = 0;
	id3_pkg::item_t file_bytes[$];

	always #6 clk = ~clk;

	id3v2_frame_parser_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	id3_field_check field_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	// receiver stalls at random
	always @(posedge clk)
		m_axis_tready <= steady || ($urandom_range(99) >= GAP_PCT);

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready)) begin
			quiet <= 0;
		end else if (quiet == WATCHDOG_LIMIT) begin
			$display("FAIL id3v2_frame_parser_top");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic add_byte(input logic [7:0] b);
		id3_pkg::item_t it;
		it.start_of_file = 1'b0;
		it.data_byte     = b;
		file_bytes.push_back(it);
	endtask

	// big-endian word
	task automatic add_word(input logic [31:0] w);
		add_byte(w[31:24]);
		add_byte(w[23:16]);
		add_byte(w[15:8]);
		add_byte(w[7:0]);
	endtask

	// send the built file with random gaps, then clear it
	task automatic play();
		for (int i = 0; i < file_bytes.size(); i++) begin
			while (!steady && $urandom_range(99) < GAP_PCT) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= file_bytes[i].data_byte;
			s_axis_tuser  <= file_bytes[i].start_of_file;
			do @(posedge clk); while (!s_axis_tready);
		end
		sent += file_bytes.size();
		file_bytes.delete();
	endtask

	// hold the sender until every expected field has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin : stimulus
		int          pick;
		int          n;
		int          nfr;
		int          files;
		logic [31:0] fid;
		logic [31:0] fsize;
		logic [31:0] total;
		logic [31:0] tsize;
		logic        bad;
		logic [7:0]  body[$];
		files = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no ID3 mark, every byte at its maximum
		for (int i = 0; i < 10; i++)
			add_byte(8'hFF);
		file_bytes[0].start_of_file = 1'b1;
		// valid mark with a zero tag size
		add_word({id3_pkg::MARK_ID3, 8'h03});
		add_byte(8'h00);
		add_byte(8'h00);
		add_word(32'd0);
		file_bytes[10].start_of_file = 1'b1;
		// bytes while idle are dropped
		add_byte(8'h80);
		add_byte(8'h7F);
		add_byte(8'h00);
		play();

		while (sent < ITEM_TARGET) begin
			files++;
			if (files == 8)
				drain();
			steady <= (files >= 14 && files < 22);
			pick = $urandom_range(99);
			if (pick < 8) begin
				// noise, with or without a restart
				n = $urandom_range(1, 15);
				for (int i = 0; i < n; i++)
					add_byte(8'($urandom_range(255)));
				file_bytes[0].start_of_file = 1'($urandom_range(1));
			end else if (pick < 14) begin
				// header of random bytes, sometimes with the mark, then junk
				for (int i = 0; i < 10; i++)
					add_byte(8'($urandom_range(255)));
				if ($urandom_range(1) == 1) begin
					file_bytes[0].data_byte = id3_pkg::MARK_ID3[23:16];
					file_bytes[1].data_byte = id3_pkg::MARK_ID3[15:8];
					file_bytes[2].data_byte = id3_pkg::MARK_ID3[7:0];
				end
				n = $urandom_range(20);
				for (int i = 0; i < n; i++)
					add_byte(8'($urandom_range(255)));
				file_bytes[0].start_of_file = 1'b1;
			end else begin
				// tag with frames, at times with a flipped mark bit or a bad frame; size bytes are filled in after the frames
				add_word({id3_pkg::MARK_ID3, 8'($urandom_range(255))});
				add_byte(8'($urandom_range(255)));
				add_byte(8'($urandom_range(255)));
				add_word(32'd0);
				file_bytes[0].start_of_file = 1'b1;
				if ($urandom_range(19) == 0) begin
					n = $urandom_range(2);
					file_bytes[n].data_byte = file_bytes[n].data_byte ^ 8'(1 << $urandom_range(7));
				end
				total = 32'd0;
				bad   = 1'b0;
				nfr   = $urandom_range(1, 4);
				for (int f = 0; f < nfr && !bad; f++) begin
					body.delete();
					pick = $urandom_range(11);
					if (pick < 6) begin
						// text frame: encoding, text, maybe a terminator and trailing bytes
						case (pick)
							0:       fid = id3_pkg::ID_TIT2;
							1:       fid = id3_pkg::ID_TPE1;
							2:       fid = id3_pkg::ID_TALB;
							3:       fid = id3_pkg::ID_TYER;
							4:       fid = id3_pkg::ID_COMM;
							default: fid = id3_pkg::ID_TCON;
						endcase
						body.push_back(8'($urandom_range(255)));
						n = $urandom_range(10);
						for (int i = 0; i < n; i++)
							body.push_back(8'($urandom_range(1, 255)));
						if ($urandom_range(9) < 4) begin
							body.push_back(8'd0);
							n = $urandom_range(3);
							for (int i = 0; i < n; i++)
								body.push_back(8'($urandom_range(255)));
						end
						fsize = body.size();
					end else if (pick < 9) begin
						// picture: encoding, mime, type, description, image
						fid = id3_pkg::ID_APIC;
						body.push_back(8'($urandom_range(255)));
						n = $urandom_range(4);
						for (int i = 0; i < n; i++)
							body.push_back(8'($urandom_range(1, 255)));
						body.push_back(8'd0);
						body.push_back(8'($urandom_range(255)));
						n = $urandom_range(3);
						for (int i = 0; i < n; i++)
							body.push_back(8'($urandom_range(1, 255)));
						body.push_back(8'd0);
						n = $urandom_range(10);
						for (int i = 0; i < n; i++)
							body.push_back(8'($urandom_range(255)));
						fsize = body.size();
						// picture frame at times cut short, which may end before the image
						if ($urandom_range(4) == 0)
							fsize = $urandom_range(1, body.size());
					end else if (pick < 11) begin
						// frame with an id the parser skips
						fid = $urandom;
						n = $urandom_range(1, 8);
						for (int i = 0; i < n; i++)
							body.push_back(8'($urandom_range(255)));
						fsize = body.size();
					end else begin
						// bad frame size: zero or top bit set
						fid   = $urandom;
						fsize = ($urandom_range(1) == 1) ? 32'd0 : {1'b1, 31'($urandom)};
						bad   = 1'b1;
					end
					add_word(fid);
					add_word(fsize);
					add_byte(8'($urandom_range(255)));
					add_byte(8'($urandom_range(255)));
					if (!bad) begin
						for (int i = 0; i < fsize; i++)
							add_byte(body[i]);
						total = total + id3_pkg::FHDR_LEN + fsize;
					end else begin
						n = $urandom_range(4);
						for (int i = 0; i < n; i++)
							add_byte(8'($urandom_range(255)));
					end
				end
				// tag size: exact, short, long with padding, or raw bytes
				pick = $urandom_range(9);
				if (bad)
					tsize = total + 32'($urandom_range(1, 200));
				else if (pick < 6)
					tsize = total;
				else if (pick < 8)
					tsize = 32'($urandom_range(1, total));
				else
					tsize = total + 32'($urandom_range(1, 30));
				if (!bad && pick == 8) begin
					n = $urandom_range(12);
					for (int i = 0; i < n; i++)
						add_byte(8'd0);
				end
				file_bytes[6].data_byte = {1'b0, tsize[27:21]};
				file_bytes[7].data_byte = {1'b0, tsize[20:14]};
				file_bytes[8].data_byte = {1'b0, tsize[13:7]};
				file_bytes[9].data_byte = {1'b0, tsize[6:0]};
				if (!bad && pick == 9) begin
					for (int i = 6; i < 10; i++)
						file_bytes[i].data_byte = 8'($urandom_range(255));
				end
			end
			// now and then a restart in the middle of a file
			if ($urandom_range(19) == 0)
				file_bytes[$urandom_range(file_bytes.size() - 1)].start_of_file = 1'b1;
			play();
		end

		steady <= 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("PASS id3v2_frame_parser_top");
		else
			$display("FAIL id3v2_frame_parser_top");
		$finish;
	end

endmodule
